FILE: sv/trs_pkg.sv
// Package for the transform-to-MVP block: shared types, sizes and the
// saturation helper. No dependencies.
package trs_pkg;

    localparam int NUM_COLS  = 4;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 4;
    localparam int WORD_W    = 32;
    localparam int WIDE_W    = 64;
    localparam int IN_W      = 10 * WORD_W;
    localparam int OUT_W     = 8 * WORD_W;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [1:0]               col_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic word_t sat32(input wide_t v);
        word_t r;
        if (v > wide_t'(64'sh7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -wide_t'(64'sh8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/trs_transform_to_mvp.sv
// Top level of the transform-to-MVP block: builds the model matrix from
// position, quaternion and scale, then multiplies by the configured VP matrix.
// Depends on trs_pkg.
//
// Usage:
//  - s_ channel: one transform per beat; s_tdata packs pos_x, pos_y, pos_z,
//    quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z (lowest first).
//  - m_ channel: four beats per transform, one matrix column each; m_tuser
//    carries column_index, m_tlast marks column 3.
//  - cfg channel: cfg_index selects one of eight 64-bit VP registers; indexes
//    beyond 7 are accepted and ignored. Write only while the block is idle.
//  - Throughput: one output beat per cycle while m_ is not stalled; a
//    new transform is taken while the previous one's columns are in flight.
//    The single column datapath is shared by the four columns.
//  - Path: an accepted transform is registered in the input hold, then in each pipeline stage.
//  - Reset: VP returns to identity, all pipeline stages are emptied.
//  - Stall: when m_tvalid is high and m_tready is low the whole pipeline holds;
//    nothing is lost or repeated, and s_tready drops until the pipeline moves again.
module trs_transform_to_mvp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, scale_x..z
    input  logic [trs_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // mvp_row0..mvp_row3, model_row0..model_row3
    output logic [trs_pkg::OUT_W-1:0]   m_tdata,
    // column_index
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [trs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [63:0]                 cfg_data
);
    import trs_pkg::*;

    localparam wide_t ONE_W = wide_t'(64'sd1) <<< FRAC_BITS;
    localparam word_t ONE   = ONE_W[WORD_W-1:0];

    logic en;
    assign en        = !m_tvalid || m_tready;
    assign cfg_ready = 1'b1;

    // VP registers
    logic [63:0] vp_reg [NUM_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg[0] <= {32'd0, ONE};
            vp_reg[1] <= 64'd0;
            vp_reg[2] <= {ONE, 32'd0};
            vp_reg[3] <= 64'd0;
            vp_reg[4] <= 64'd0;
            vp_reg[5] <= {32'd0, ONE};
            vp_reg[6] <= 64'd0;
            vp_reg[7] <= {ONE, 32'd0};
        end else if (cfg_valid && cfg_index < IDX_W'(NUM_REGS)) begin
            vp_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    function automatic word_t vp_at(input int r, input int k);
        logic [63:0] w;
        w = vp_reg[2 * k + r / 2];
        return (r % 2 == 1) ? w[63:32] : w[31:0];
    endfunction

    // Input hold: one transform, replayed as four column beats
    logic        hold_valid_reg;
    col_t        hold_col_reg;
    word_t       hold_reg [10];

    assign s_tready = en && (!hold_valid_reg || hold_col_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            hold_col_reg   <= 2'd0;
        end else if (s_tvalid && s_tready) begin
            hold_valid_reg <= 1'b1;
            hold_col_reg   <= 2'd0;
        end else if (en && hold_valid_reg) begin
            hold_col_reg <= hold_col_reg + 2'd1;
            if (hold_col_reg == 2'd3) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            for (int i = 0; i < 10; i++) begin
                hold_reg[i] <= s_tdata[i*WORD_W +: WORD_W];
            end
        end
    end

    // Stage 1: floored quaternion products
    logic  v1_reg;
    col_t  col1_reg;
    wide_t q1_reg [9];   // xx yy zz xy xz yz wx wy wz
    word_t pos1_reg [3];
    word_t scl1_reg [3];

    function automatic wide_t fmul(input word_t a, input word_t b);
        wide_t p;
        p = wide_t'(a) * wide_t'(b);
        return p >>> FRAC_BITS;
    endfunction

    // Stage 2: rotation column, scale select
    logic  v2_reg;
    col_t  col2_reg;
    word_t rc2_reg [3];
    word_t s2_reg;
    word_t pos2_reg [3];

    logic signed [WIDE_W-1:0] rt [9];
    always_comb begin
        rt[0] = ONE_W - 2 * (q1_reg[1] + q1_reg[2]);
        rt[1] = 2 * (q1_reg[3] + q1_reg[8]);
        rt[2] = 2 * (q1_reg[4] - q1_reg[7]);
        rt[3] = 2 * (q1_reg[3] - q1_reg[8]);
        rt[4] = ONE_W - 2 * (q1_reg[0] + q1_reg[2]);
        rt[5] = 2 * (q1_reg[5] + q1_reg[6]);
        rt[6] = 2 * (q1_reg[4] + q1_reg[7]);
        rt[7] = 2 * (q1_reg[5] - q1_reg[6]);
        rt[8] = ONE_W - 2 * (q1_reg[0] + q1_reg[1]);
    end

    // Stage 3: rotation times scale, exact
    logic  v3_reg;
    col_t  col3_reg;
    wide_t p3_reg [3];
    word_t pos3_reg [3];

    // Stage 4: model column
    logic  v4_reg;
    col_t  col4_reg;
    word_t m4_reg [4];

    // Stage 5: VP times model column, floored products
    logic  v5_reg;
    col_t  col5_reg;
    wide_t p5_reg [4][4];
    word_t m5_reg [4];

    // Stage 6: output register
    logic  v6_reg;
    col_t  col6_reg;
    word_t mvp6_reg [4];
    word_t m6_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= hold_valid_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            col1_reg  <= hold_col_reg;
            q1_reg[0] <= fmul(hold_reg[3], hold_reg[3]);
            q1_reg[1] <= fmul(hold_reg[4], hold_reg[4]);
            q1_reg[2] <= fmul(hold_reg[5], hold_reg[5]);
            q1_reg[3] <= fmul(hold_reg[3], hold_reg[4]);
            q1_reg[4] <= fmul(hold_reg[3], hold_reg[5]);
            q1_reg[5] <= fmul(hold_reg[4], hold_reg[5]);
            q1_reg[6] <= fmul(hold_reg[6], hold_reg[3]);
            q1_reg[7] <= fmul(hold_reg[6], hold_reg[4]);
            q1_reg[8] <= fmul(hold_reg[6], hold_reg[5]);
            for (int i = 0; i < 3; i++) begin
                pos1_reg[i] <= hold_reg[i];
                scl1_reg[i] <= hold_reg[7 + i];
            end

            // stage 2
            col2_reg <= col1_reg;
            pos2_reg <= pos1_reg;
            case (col1_reg)
                2'd0: begin
                    for (int r = 0; r < 3; r++) rc2_reg[r] <= sat32(rt[r]);
                    s2_reg <= scl1_reg[0];
                end
                2'd1: begin
                    for (int r = 0; r < 3; r++) rc2_reg[r] <= sat32(rt[3 + r]);
                    s2_reg <= scl1_reg[1];
                end
                default: begin
                    for (int r = 0; r < 3; r++) rc2_reg[r] <= sat32(rt[6 + r]);
                    s2_reg <= scl1_reg[2];
                end
            endcase

            // stage 3
            col3_reg <= col2_reg;
            pos3_reg <= pos2_reg;
            for (int r = 0; r < 3; r++) begin
                p3_reg[r] <= wide_t'(rc2_reg[r]) * wide_t'(s2_reg);
            end

            // stage 4: translation column passes straight through
            col4_reg <= col3_reg;
            if (col3_reg == 2'd3) begin
                for (int r = 0; r < 3; r++) m4_reg[r] <= pos3_reg[r];
                m4_reg[3] <= ONE;
            end else begin
                for (int r = 0; r < 3; r++) m4_reg[r] <= sat32(p3_reg[r] >>> FRAC_BITS);
                m4_reg[3] <= '0;
            end

            // stage 5
            col5_reg <= col4_reg;
            m5_reg   <= m4_reg;
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 4; k++) begin
                    p5_reg[r][k] <= fmul(vp_at(r, k), m4_reg[k]);
                end
            end

            // stage 6
            col6_reg <= col5_reg;
            m6_reg   <= m5_reg;
            for (int r = 0; r < 4; r++) begin
                mvp6_reg[r] <= sat32(p5_reg[r][0] + p5_reg[r][1]
                                     + p5_reg[r][2] + p5_reg[r][3]);
            end
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tuser  = col6_reg;
    assign m_tlast  = (col6_reg == 2'd3);

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            m_tdata[r*WORD_W +: WORD_W]       = mvp6_reg[r];
            m_tdata[(4 + r)*WORD_W +: WORD_W] = m6_reg[r];
        end
    end

endmodule
